// ===== rtl/mtp_pkg.sv =====
// Shared types and constants for the MAC address text parser.
package mtp_pkg;

	localparam int ADDR_W = 48;

	localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
	localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_F = 8'h46;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_F = 8'h66;
	localparam logic [7:0] CHAR_COLON   = 8'h3a;
	localparam logic [7:0] HEX_TEN      = 8'h0a;

	typedef enum logic [1:0] {
		ST_COLON = 2'd0,
		ST_PLAIN = 2'd1,
		ST_BAD   = 2'd2
	} mtp_status_t;

	typedef struct packed {
		logic       is_hex;
		logic       is_colon;
		logic [3:0] nibble;
	} mtp_char_class_t;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		mtp_status_t       status;
	} mtp_result_t;

endpackage

// ===== rtl/mtp_hex_decode.sv =====
// Character classifier: hex digit value and colon detect.
module mtp_hex_decode
	import mtp_pkg::*;
(
	input  logic [7:0]      character,
	output mtp_char_class_t cls
);

	logic [7:0] off_digit;
	logic [7:0] off_upper;
	logic [7:0] off_lower;

	assign off_digit = character - CHAR_DIGIT_0;
	assign off_upper = character - CHAR_UPPER_A + HEX_TEN;
	assign off_lower = character - CHAR_LOWER_A + HEX_TEN;

	always_comb begin
		cls.is_hex   = 1'b1;
		cls.is_colon = (character == CHAR_COLON);
		cls.nibble   = 4'd0;
		if (character inside {[CHAR_DIGIT_0:CHAR_DIGIT_9]}) begin
			cls.nibble = off_digit[3:0];
		end else if (character inside {[CHAR_UPPER_A:CHAR_UPPER_F]}) begin
			cls.nibble = off_upper[3:0];
		end else if (character inside {[CHAR_LOWER_A:CHAR_LOWER_F]}) begin
			cls.nibble = off_lower[3:0];
		end else begin
			cls.is_hex = 1'b0;
		end
	end

endmodule

// ===== rtl/mtp_form_tracker.sv =====
// Per-string state for both layouts and the end-of-string verdict.
module mtp_form_tracker
	import mtp_pkg::*;
#(
	parameter int ADDRESS_BYTES = 6
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  logic            last,
	input  mtp_char_class_t cls,
	output mtp_result_t     result
);

	localparam int COLON_LEN = 3 * ADDRESS_BYTES - 1;
	localparam int PLAIN_LEN = 2 * ADDRESS_BYTES;
	localparam int VW        = 8 * ADDRESS_BYTES;
	localparam int PW        = $clog2(COLON_LEN + 1);

	logic [PW-1:0] pos_q, pos_n;
	logic [1:0]    phase_q, phase_n;
	logic          colon_ok_q, colon_ok_n;
	logic          plain_ok_q, plain_ok_n;
	logic [VW-1:0] colon_val_q, colon_val_n;
	logic [VW-1:0] plain_val_q, plain_val_n;
	logic          colon_active, plain_active, colon_slot;
	logic [ADDR_W-1:0] colon_addr, plain_addr;

	assign colon_active = pos_q < PW'(COLON_LEN);
	assign plain_active = pos_q < PW'(PLAIN_LEN);
	assign colon_slot   = (phase_q == 2'd2);

	always_comb begin
		colon_ok_n  = colon_ok_q;
		colon_val_n = colon_val_q;
		pos_n       = pos_q;
		phase_n     = phase_q;
		if (colon_active) begin
			pos_n   = pos_q + PW'(1);
			phase_n = colon_slot ? 2'd0 : phase_q + 2'd1;
			if (colon_slot) begin
				if (!cls.is_colon) colon_ok_n = 1'b0;
			end else if (!cls.is_hex) begin
				colon_ok_n = 1'b0;
			end else begin
				colon_val_n = {colon_val_q[VW-5:0], cls.nibble};
			end
		end
		plain_ok_n  = plain_ok_q;
		plain_val_n = plain_val_q;
		if (plain_active) begin
			if (!cls.is_hex) begin
				plain_ok_n = 1'b0;
			end else begin
				plain_val_n = {plain_val_q[VW-5:0], cls.nibble};
			end
		end
	end

	generate
		if (VW >= ADDR_W) begin : g_wide
			assign colon_addr = colon_val_n[ADDR_W-1:0];
			assign plain_addr = plain_val_n[ADDR_W-1:0];
		end else begin : g_narrow
			assign colon_addr = {{(ADDR_W-VW){1'b0}}, colon_val_n};
			assign plain_addr = {{(ADDR_W-VW){1'b0}}, plain_val_n};
		end
	endgenerate

	// Colon layout wins over plain when both are complete and clean.
	always_comb begin
		if (colon_ok_n && pos_n >= PW'(COLON_LEN)) begin
			result.address = colon_addr;
			result.status  = ST_COLON;
		end else if (plain_ok_n && pos_n >= PW'(PLAIN_LEN)) begin
			result.address = plain_addr;
			result.status  = ST_PLAIN;
		end else begin
			result.address = '0;
			result.status  = ST_BAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			phase_q     <= 2'd0;
			colon_ok_q  <= 1'b1;
			plain_ok_q  <= 1'b1;
			colon_val_q <= '0;
			plain_val_q <= '0;
		end else if (advance) begin
			if (last) begin
				pos_q       <= '0;
				phase_q     <= 2'd0;
				colon_ok_q  <= 1'b1;
				plain_ok_q  <= 1'b1;
				colon_val_q <= '0;
				plain_val_q <= '0;
			end else begin
				pos_q       <= pos_n;
				phase_q     <= phase_n;
				colon_ok_q  <= colon_ok_n;
				plain_ok_q  <= plain_ok_n;
				colon_val_q <= colon_val_n;
				plain_val_q <= plain_val_n;
			end
		end
	end

endmodule

// ===== rtl/mac_address_text_parser_top.sv =====
// Top level of the MAC address text parser: input handshake and result register.
//
// Usage:
//   Input channel (in_valid/in_ready, character, last) takes one ASCII character
//   per transfer; last marks the final character of a string. Every string
//   yields exactly one result transfer on the output channel
//   (out_valid/out_ready, address, status): status 0 for the colon layout
//   xx:xx:xx:xx:xx:xx, 1 for twelve plain hex digits, 2 for invalid with
//   address zero. Characters past the layout length are ignored.
// Timing:
//   One character per cycle sustained unless a stall drops in_ready (below). The
//   result appears on out_valid in the cycle after the transfer of the last
//   character; the per-string state is updated in the same cycle as each input
//   transfer, so there is no other pipeline latency.
// Stall and reset:
//   A single result register holds the verdict; while it is full and the
//   receiver holds out_ready low, in_ready drops and input stalls. When the
//   receiver takes the result, a new character is accepted in that same cycle.
//   arst_n clears both layouts' state and empties the result register.
module mac_address_text_parser_top
	import mtp_pkg::*;
#(
	parameter int ADDRESS_BYTES = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        character,
	input  logic              last,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ADDR_W-1:0] address,
	output logic [1:0]        status
);

	mtp_char_class_t cls;
	mtp_result_t     result;
	logic            in_xfer;
	logic            out_valid_q;
	mtp_result_t     result_q;

	// Accept while the result register is empty or being drained this cycle.
	assign in_ready = !out_valid_q || out_ready;
	assign in_xfer  = in_valid && in_ready;

	mtp_hex_decode u_decode (
		.character (character),
		.cls       (cls)
	);

	mtp_form_tracker #(
		.ADDRESS_BYTES (ADDRESS_BYTES)
	) u_tracker (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (in_xfer),
		.last    (last),
		.cls     (cls),
		.result  (result)
	);

	// Load the verdict on the last character; drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer && last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && last) begin
			result_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign address   = result_q.address;
	assign status    = result_q.status;

`ifndef ASSERT_OFF
	a_bad_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.status == ST_BAD |-> result_q.address == '0)
		else $error("invalid result carries a nonzero address");

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && last |=> out_valid_q)
		else $error("last character transfer did not load a result");

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(in_xfer && last))
		else $error("result appeared without a last character");

	a_empty_takes_input: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with an empty result register");
`endif

endmodule
